// File: sv/hee_pkg.sv
`timescale 1ns / 1ps

package hee_pkg;

	// longest escaped form, in characters
	localparam int MAX_CHARS = 6;
	localparam int POS_W     = $clog2(MAX_CHARS);

	typedef logic [7:0]       char_t;
	typedef logic [POS_W-1:0] pos_t;

	// characters that take part in escaping
	localparam char_t CH_TAB   = 8'h09;
	localparam char_t CH_LF    = 8'h0a;
	localparam char_t CH_DQUOT = 8'h22;
	localparam char_t CH_HASH  = 8'h23;
	localparam char_t CH_AMP   = 8'h26;
	localparam char_t CH_APOS  = 8'h27;
	localparam char_t CH_SEMI  = 8'h3b;
	localparam char_t CH_LT    = 8'h3c;
	localparam char_t CH_GT    = 8'h3e;
	localparam char_t CH_ZERO  = 8'h30;

	// one escaped run: chars[0] goes out first, len is 1 to MAX_CHARS
	typedef struct packed {
		char_t [MAX_CHARS-1:0] chars;
		pos_t                  len;
	} run_t;

endpackage

// File: sv/hee_expand.sv
`timescale 1ns / 1ps

module hee_expand (
	input  hee_pkg::char_t text_byte,
	input  logic           keep_non_ascii,
	output hee_pkg::run_t  run
);

	logic [1:0]     hund;
	logic [7:0]     hund_val;
	logic [6:0]     rem;
	logic [14:0]    tens_prod;
	logic [3:0]     tens;
	logic [6:0]     tens_x10;
	logic [3:0]     ones;
	hee_pkg::char_t ch_h;
	hee_pkg::char_t ch_t;
	hee_pkg::char_t ch_o;
	logic           numeric;

	// decimal digits of the byte
	always_comb begin
		if (text_byte >= 8'd200) begin
			hund     = 2'd2;
			hund_val = 8'd200;
		end else if (text_byte >= 8'd100) begin
			hund     = 2'd1;
			hund_val = 8'd100;
		end else begin
			hund     = 2'd0;
			hund_val = 8'd0;
		end
		rem       = 7'(text_byte - hund_val);
		// rem / 10 through the reciprocal 205 / 2048, exact below 100
		tens_prod = 15'({8'd0, rem} * 15'd205);
		tens      = tens_prod[14:11];
		tens_x10  = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
		ones      = 4'(rem - tens_x10);
		ch_h      = hee_pkg::CH_ZERO + {6'd0, hund};
		ch_t      = hee_pkg::CH_ZERO + {4'd0, tens};
		ch_o      = hee_pkg::CH_ZERO + {4'd0, ones};
	end

	always_comb begin
		run       = '0;
		run.len   = hee_pkg::pos_t'(1);
		run.chars[0] = text_byte;
		numeric   = 1'b0;
		case (text_byte)
			hee_pkg::CH_AMP: begin
				run.chars[0] = hee_pkg::CH_AMP;
				run.chars[1] = 8'h61;
				run.chars[2] = 8'h6d;
				run.chars[3] = 8'h70;
				run.chars[4] = hee_pkg::CH_SEMI;
				run.len      = hee_pkg::pos_t'(5);
			end
			hee_pkg::CH_LT: begin
				run.chars[0] = hee_pkg::CH_AMP;
				run.chars[1] = 8'h6c;
				run.chars[2] = 8'h74;
				run.chars[3] = hee_pkg::CH_SEMI;
				run.len      = hee_pkg::pos_t'(4);
			end
			hee_pkg::CH_GT: begin
				run.chars[0] = hee_pkg::CH_AMP;
				run.chars[1] = 8'h67;
				run.chars[2] = 8'h74;
				run.chars[3] = hee_pkg::CH_SEMI;
				run.len      = hee_pkg::pos_t'(4);
			end
			hee_pkg::CH_DQUOT: begin
				run.chars[0] = hee_pkg::CH_AMP;
				run.chars[1] = 8'h71;
				run.chars[2] = 8'h75;
				run.chars[3] = 8'h6f;
				run.chars[4] = 8'h74;
				run.chars[5] = hee_pkg::CH_SEMI;
				run.len      = hee_pkg::pos_t'(6);
			end
			hee_pkg::CH_APOS: begin
				run.chars[0] = hee_pkg::CH_AMP;
				run.chars[1] = 8'h61;
				run.chars[2] = 8'h70;
				run.chars[3] = 8'h6f;
				run.chars[4] = 8'h73;
				run.chars[5] = hee_pkg::CH_SEMI;
				run.len      = hee_pkg::pos_t'(6);
			end
			hee_pkg::CH_TAB, hee_pkg::CH_LF: begin
				run.chars[0] = text_byte;
			end
			default: begin
				if (text_byte inside {[8'h00:8'h1f]}) begin
					numeric = 1'b1;
				end else if (text_byte inside {[8'h80:8'hff]}) begin
					numeric = !keep_non_ascii;
				end
			end
		endcase

		if (numeric) begin
			run.chars[0] = hee_pkg::CH_AMP;
			run.chars[1] = hee_pkg::CH_HASH;
			if (hund != 2'd0) begin
				run.chars[2] = ch_h;
				run.chars[3] = ch_t;
				run.chars[4] = ch_o;
				run.chars[5] = hee_pkg::CH_SEMI;
				run.len      = hee_pkg::pos_t'(6);
			end else if (tens != 4'd0) begin
				run.chars[2] = ch_t;
				run.chars[3] = ch_o;
				run.chars[4] = hee_pkg::CH_SEMI;
				run.len      = hee_pkg::pos_t'(5);
			end else begin
				run.chars[2] = ch_o;
				run.chars[3] = hee_pkg::CH_SEMI;
				run.len      = hee_pkg::pos_t'(4);
			end
		end
	end

endmodule

// File: sv/hee_serial.sv
`timescale 1ns / 1ps

module hee_serial (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load_valid,
	input  hee_pkg::run_t  load_run,
	input  logic           load_final,
	output logic           load_take,
	output logic           out_valid,
	input  logic           out_stall,
	output hee_pkg::char_t out_char,
	output logic           run_last,
	output logic           text_done
);

	hee_pkg::run_t run_s2;
	logic          final_s2;
	logic          valid_s2;
	hee_pkg::pos_t pos_q;
	logic          last;
	logic          out_fire;

	assign last      = (pos_q == run_s2.len - hee_pkg::pos_t'(1));
	assign out_fire  = valid_s2 && !out_stall;
	// buffer frees on the final character of its run
	assign load_take = !valid_s2 || (out_fire && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			pos_q    <= '0;
		end else begin
			if (load_take) begin
				valid_s2 <= load_valid;
				pos_q    <= '0;
			end else if (out_fire) begin
				pos_q <= pos_q + hee_pkg::pos_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_take && load_valid) begin
			run_s2   <= load_run;
			final_s2 <= load_final;
		end
	end

	assign out_valid = valid_s2;
	assign out_char  = run_s2.chars[pos_q];
	assign run_last  = last;
	assign text_done = last && final_s2;

endmodule

// File: sv/html_entity_encoder.sv
`timescale 1ns / 1ps

// channel   direction  handshake           payload
// in        to block   in_valid/in_stall    text_byte, final_byte
// out       from block out_valid/out_stall  out_char, run_last, text_done
// cfg       to block   cfg_we               cfg_wdata (keep_non_ascii)
//
// a byte leaves as its escaped form of 1 to 6 characters,
// sent by the output buffer one character per cycle while out_stall is low
// a request is held in the input register, then the output buffer
// the input register takes the next request while a run is still draining
// arst_n clears the valid flags and keep_non_ascii, no clearing pass
// out_stall holds the current character and fills the input register

module html_entity_encoder (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	input  logic           in_valid,
	output logic           in_stall,
	input  hee_pkg::char_t text_byte,
	input  logic           final_byte,
	output logic           out_valid,
	input  logic           out_stall,
	output hee_pkg::char_t out_char,
	output logic           run_last,
	output logic           text_done
);

	// mode register
	logic keep_non_ascii_q;

	// input register
	logic           valid_s1;
	hee_pkg::char_t byte_s1;
	logic           final_s1;

	logic          take;
	logic          in_fire;
	hee_pkg::run_t run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_non_ascii_q <= 1'b0;
		end else if (cfg_we) begin
			keep_non_ascii_q <= cfg_wdata;
		end
	end

	// stall only while a request sits here and the buffer is still busy
	assign in_stall = valid_s1 && !take;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1  <= text_byte;
			final_s1 <= final_byte;
		end
	end

	// escape lookup between the input register and the output buffer
	hee_expand u_expand (
		.text_byte      (byte_s1),
		.keep_non_ascii (keep_non_ascii_q),
		.run            (run)
	);

	// output buffer, one character per cycle while out_stall is low
	hee_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_run   (run),
		.load_final (final_s1),
		.load_take  (take),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.run_last   (run_last),
		.text_done  (text_done)
	);

endmodule

// File: sv/hee_checker.sv
`timescale 1ns / 1ps

module hee_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_stall,
	input hee_pkg::char_t out_char,
	input logic           out_valid,
	input logic           out_stall,
	input logic           run_last,
	input logic           text_done
);

	// stalled character holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_char)
			&& $stable(run_last) && $stable(text_done))
		else $error("stalled output changed");

	// end of text only on the end of a run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_done |-> run_last)
		else $error("text_done without run_last");

	// a multi-character run always opens with an ampersand
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && run_last
			|=> !out_valid || run_last || out_char == hee_pkg::CH_AMP)
		else $error("multi-character run without leading ampersand");

	// input stalls only while output has something pending
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

endmodule

bind html_entity_encoder hee_checker u_chk (.*);
